### hdl/mtms_pkg.sv
// Shared types, constants and helper functions of the multiscale tile maximum suppression block.
package mtms_pkg;

    localparam int LEVELS    = 4;
    localparam int LEVEL_W   = 2;
    localparam int RESP_W    = 8;
    localparam int MAX_DIM   = 1024;
    localparam int DIM_W     = 10;
    localparam int SIZE_W    = 11;
    localparam int MAX_TILE  = 15;
    localparam int TILE_W    = 4;
    localparam int THR_W     = 9;
    localparam int RADIUS_W  = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 40;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_TILE_SIZE = 3'd0;
    localparam logic [2:0] REG_WIDTH     = 3'd1;
    localparam logic [2:0] REG_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_RADIUS0   = 3'd4;
    localparam logic [2:0] REG_RADIUS1   = 3'd5;
    localparam logic [2:0] REG_RADIUS2   = 3'd6;
    localparam logic [2:0] REG_RADIUS3   = 3'd7;

    typedef struct packed {
        logic [TILE_W-1:0] tile_size;
        logic [SIZE_W-1:0] width;
        logic [SIZE_W-1:0] height;
    } geom_cfg_t;

    typedef struct packed {
        logic [THR_W-1:0]                   threshold;
        logic [LEVELS-1:0][RADIUS_W-1:0]    radius;
    } back_cfg_t;

    // One pixel of an in-frame tile, already reduced to its best level.
    typedef struct packed {
        logic [DIM_W-1:0]   slot;
        logic [DIM_W-1:0]   row;
        logic [DIM_W-1:0]   col;
        logic [RESP_W-1:0]  value;
        logic [LEVEL_W-1:0] level;
        logic               first;
        logic               last;
    } q_item_t;

    // Running tile maximum as kept per tile column.
    typedef struct packed {
        logic [RESP_W-1:0]  value;
        logic [DIM_W-1:0]   row;
        logic [DIM_W-1:0]   col;
        logic [LEVEL_W-1:0] level;
    } acc_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

    function automatic logic [TILE_W-1:0] eff_tile(input logic [TILE_W-1:0] ts);
        logic [TILE_W-1:0] r;
        if (ts == '0) begin
            r = TILE_W'(1);
        end else if (32'(ts) > MAX_TILE) begin
            r = TILE_W'(MAX_TILE);
        end else begin
            r = ts;
        end
        return r;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_dim(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            r = SIZE_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### hdl/mtms_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mtms_front.sv
// Front part: raster counters, tile classification and per-pixel level maximum.
module mtms_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtms_pkg::geom_cfg_t           geom,
    input  logic                          restart,
    input  logic                          accept,
    input  logic [mtms_pkg::S_DATA_W-1:0] s_tdata,
    output logic                          push,
    output mtms_pkg::q_item_t             item
);

    logic [mtms_pkg::DIM_W-1:0]  col_reg, col_next;
    logic [mtms_pkg::DIM_W-1:0]  row_reg, row_next;
    logic [mtms_pkg::TILE_W-1:0] offc_reg, offc_next;
    logic [mtms_pkg::TILE_W-1:0] offr_reg, offr_next;
    logic [mtms_pkg::DIM_W-1:0]  tci_reg, tci_next;

    logic [mtms_pkg::TILE_W-1:0] ts;
    logic [mtms_pkg::SIZE_W-1:0] w;
    logic [mtms_pkg::SIZE_W-1:0] h;
    logic [mtms_pkg::DIM_W-1:0]  col_start;
    logic [mtms_pkg::DIM_W-1:0]  row_start;
    logic                        in_frame;
    logic [mtms_pkg::RESP_W-1:0]  pmax;
    logic [mtms_pkg::LEVEL_W-1:0] plev;

    assign ts = mtms_pkg::eff_tile(geom.tile_size);
    assign w  = mtms_pkg::clamp_dim(geom.width);
    assign h  = mtms_pkg::clamp_dim(geom.height);

    assign col_start = col_reg - mtms_pkg::DIM_W'(offc_reg);
    assign row_start = row_reg - mtms_pkg::DIM_W'(offr_reg);
    assign in_frame = ((12'(col_start) + 12'(ts)) <= 12'(w)) &&
                      ((12'(row_start) + 12'(ts)) <= 12'(h));

    // Later levels win ties, as when the levels are scanned in order.
    always_comb begin
        logic [mtms_pkg::RESP_W-1:0] r;
        pmax = s_tdata[mtms_pkg::RESP_W-1:0];
        plev = '0;
        for (int l = 1; l < mtms_pkg::LEVELS; l++) begin
            r = s_tdata[l*mtms_pkg::RESP_W +: mtms_pkg::RESP_W];
            if (r >= pmax) begin
                pmax = r;
                plev = mtms_pkg::LEVEL_W'(l);
            end
        end
    end

    always_comb begin
        item.slot  = tci_reg;
        item.row   = row_reg;
        item.col   = col_reg;
        item.value = pmax;
        item.level = plev;
        item.first = (offc_reg == '0) && (offr_reg == '0);
        item.last  = (offc_reg == ts - mtms_pkg::TILE_W'(1)) &&
                     (offr_reg == ts - mtms_pkg::TILE_W'(1));
    end

    assign push = accept && in_frame;

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        offc_next = offc_reg;
        offr_next = offr_reg;
        tci_next  = tci_reg;
        if (accept) begin
            col_next  = col_reg + mtms_pkg::DIM_W'(1);
            offc_next = offc_reg + mtms_pkg::TILE_W'(1);
            if ((5'(offc_reg) + 5'd1) >= 5'(ts)) begin
                offc_next = '0;
                tci_next  = tci_reg + mtms_pkg::DIM_W'(1);
            end
            if ((mtms_pkg::SIZE_W'(col_reg) + mtms_pkg::SIZE_W'(1)) >= w) begin
                col_next  = '0;
                offc_next = '0;
                tci_next  = '0;
                row_next  = row_reg + mtms_pkg::DIM_W'(1);
                offr_next = offr_reg + mtms_pkg::TILE_W'(1);
                if ((5'(offr_reg) + 5'd1) >= 5'(ts)) begin
                    offr_next = '0;
                end
                if ((mtms_pkg::SIZE_W'(row_reg) + mtms_pkg::SIZE_W'(1)) >= h) begin
                    row_next  = '0;
                    offr_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            col_reg  <= '0;
            row_reg  <= '0;
            offc_reg <= '0;
            offr_reg <= '0;
            tci_reg  <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            offc_reg <= offc_next;
            offr_reg <= offr_next;
            tci_reg  <= tci_next;
        end
    end

endmodule

### hdl/mtms_queue.sv
// Short item queue between the front and the back part.
module mtms_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  mtms_pkg::q_item_t       push_item,
    input  logic                    pop,
    output mtms_pkg::q_item_t       head,
    output mtms_pkg::q_status_t     status
);

    mtms_pkg::q_item_t               entry_reg [mtms_pkg::QUEUE_DEPTH];
    logic [mtms_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [mtms_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [mtms_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == mtms_pkg::QCNT_W'(mtms_pkg::QUEUE_DEPTH));

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + mtms_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + mtms_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + mtms_pkg::QCNT_W'(push) - mtms_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/mtms_back.sv
// Back part: per-tile-column maximum update in RAM, detection and output register.
module mtms_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mtms_pkg::back_cfg_t           cfg,
    input  mtms_pkg::q_status_t           q_status,
    input  mtms_pkg::q_item_t             q_head,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mtms_pkg::M_DATA_W-1:0] m_tdata
);

    logic                   s1_valid_reg;
    mtms_pkg::q_item_t      s1_item_reg;
    logic                   acc_valid_reg;
    logic [mtms_pkg::DIM_W-1:0] acc_slot_reg;
    mtms_pkg::acc_t         acc_reg;
    mtms_pkg::acc_t         ram_rdata;
    mtms_pkg::acc_t         base;
    mtms_pkg::acc_t         upd;
    logic                   emit;
    logic                   adv;
    logic                   m_valid_reg;
    logic [mtms_pkg::M_DATA_W-1:0] m_data_reg;

    mtms_ram #(
        .WIDTH($bits(mtms_pkg::acc_t)),
        .DEPTH(mtms_pkg::MAX_DIM)
    ) u_store (
        .aclk  (aclk),
        .we    (adv),
        .waddr (s1_item_reg.slot),
        .wdata (upd),
        .re    (pop),
        .raddr (q_head.slot),
        .rdata (ram_rdata)
    );

    // The RAM returns the old word when the previous item wrote the same slot
    // in the cycle of the read, so the last written word is forwarded.
    always_comb begin
        if (acc_valid_reg && (acc_slot_reg == s1_item_reg.slot)) begin
            base = acc_reg;
        end else begin
            base = ram_rdata;
        end
        if (s1_item_reg.first || (s1_item_reg.value >= base.value)) begin
            upd.value = s1_item_reg.value;
            upd.row   = s1_item_reg.row;
            upd.col   = s1_item_reg.col;
            upd.level = s1_item_reg.level;
        end else begin
            upd = base;
        end
    end

    assign emit = s1_item_reg.last &&
                  ({1'b0, upd.value} >= cfg.threshold);
    assign adv  = s1_valid_reg && (!emit || !m_valid_reg || m_tready);
    assign pop  = q_status.valid && (!s1_valid_reg || adv);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            acc_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                acc_valid_reg <= 1'b1;
            end
            if (adv && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_item_reg <= q_head;
        end
        if (adv) begin
            acc_reg      <= upd;
            acc_slot_reg <= s1_item_reg.slot;
        end
        if (adv && emit) begin
            m_data_reg <= {2'b00, cfg.radius[upd.level], upd.level, upd.col, upd.row};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### hdl/multiscale_tile_max_suppression.sv
// Top level: configuration registers, front part, item queue and back part.
// Throughput: one pixel per cycle while the queue has room and the output is not held,
// set by the single read and write port of the tile store.
// Reset: synchronous, active low; it clears counters, queue and output valid and loads
// the register defaults. The tile store is not cleared: each tile overwrites its entry
// at its first pixel, so no clearing pass follows reset.
module multiscale_tile_max_suppression (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // response_level0 [7:0], response_level1 [15:8], response_level2 [23:16],
    // response_level3 [31:24]
    input  logic [mtms_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // point_row [9:0], point_col [19:10], point_level [21:20], point_radius [37:22],
    // zero [39:38]
    output logic [mtms_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mtms_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mtms_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mtms_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [mtms_pkg::TILE_W-1:0]   tile_size_reg;
    logic [mtms_pkg::SIZE_W-1:0]   width_reg;
    logic [mtms_pkg::SIZE_W-1:0]   height_reg;
    logic [mtms_pkg::THR_W-1:0]    threshold_reg;
    logic [mtms_pkg::LEVELS-1:0][mtms_pkg::RADIUS_W-1:0] radius_reg;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic                  restart;
    logic                  s_accept;
    logic                  q_push;
    logic                  q_pop;
    mtms_pkg::q_item_t     q_push_item;
    mtms_pkg::q_item_t     q_head;
    mtms_pkg::q_status_t   q_stat;
    mtms_pkg::geom_cfg_t   geom;
    mtms_pkg::back_cfg_t   bcfg;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign restart = cfg_wr && ((cfg_idx == mtms_pkg::REG_TILE_SIZE) ||
                                (cfg_idx == mtms_pkg::REG_WIDTH) ||
                                (cfg_idx == mtms_pkg::REG_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tile_size_reg <= mtms_pkg::TILE_W'(3);
            width_reg     <= mtms_pkg::SIZE_W'(512);
            height_reg    <= mtms_pkg::SIZE_W'(512);
            threshold_reg <= '0;
            radius_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                mtms_pkg::REG_TILE_SIZE: begin
                    tile_size_reg <= pwdata[mtms_pkg::TILE_W-1:0];
                end
                mtms_pkg::REG_WIDTH: begin
                    width_reg <= pwdata[mtms_pkg::SIZE_W-1:0];
                end
                mtms_pkg::REG_HEIGHT: begin
                    height_reg <= pwdata[mtms_pkg::SIZE_W-1:0];
                end
                mtms_pkg::REG_THRESHOLD: begin
                    threshold_reg <= pwdata[mtms_pkg::THR_W-1:0];
                end
                mtms_pkg::REG_RADIUS0: begin
                    radius_reg[0] <= pwdata[mtms_pkg::RADIUS_W-1:0];
                end
                mtms_pkg::REG_RADIUS1: begin
                    radius_reg[1] <= pwdata[mtms_pkg::RADIUS_W-1:0];
                end
                mtms_pkg::REG_RADIUS2: begin
                    radius_reg[2] <= pwdata[mtms_pkg::RADIUS_W-1:0];
                end
                mtms_pkg::REG_RADIUS3: begin
                    radius_reg[3] <= pwdata[mtms_pkg::RADIUS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            mtms_pkg::REG_TILE_SIZE: prdata = mtms_pkg::APB_DATA_W'(tile_size_reg);
            mtms_pkg::REG_WIDTH:     prdata = mtms_pkg::APB_DATA_W'(width_reg);
            mtms_pkg::REG_HEIGHT:    prdata = mtms_pkg::APB_DATA_W'(height_reg);
            mtms_pkg::REG_THRESHOLD: prdata = mtms_pkg::APB_DATA_W'(threshold_reg);
            mtms_pkg::REG_RADIUS0:   prdata = mtms_pkg::APB_DATA_W'(radius_reg[0]);
            mtms_pkg::REG_RADIUS1:   prdata = mtms_pkg::APB_DATA_W'(radius_reg[1]);
            mtms_pkg::REG_RADIUS2:   prdata = mtms_pkg::APB_DATA_W'(radius_reg[2]);
            mtms_pkg::REG_RADIUS3:   prdata = mtms_pkg::APB_DATA_W'(radius_reg[3]);
            default:                 prdata = '0;
        endcase
    end

    always_comb begin
        geom.tile_size = tile_size_reg;
        geom.width     = width_reg;
        geom.height    = height_reg;
        bcfg.threshold = threshold_reg;
        bcfg.radius    = radius_reg;
    end

    assign s_tready = !q_stat.full;
    assign s_accept = s_tvalid && s_tready;

    mtms_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .geom    (geom),
        .restart (restart),
        .accept  (s_accept),
        .s_tdata (s_tdata),
        .push    (q_push),
        .item    (q_push_item)
    );

    mtms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_stat)
    );

    mtms_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (bcfg),
        .q_status (q_stat),
        .q_head   (q_head),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // The front never pushes into a full queue.
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full))
        else $error("item pushed into a full queue");

    // The back only takes an item that the queue holds.
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_stat.valid)
        else $error("item popped from an empty queue");

    // A pushed item leaves the queue non-empty in the next cycle.
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !q_pop) |=> q_stat.valid)
        else $error("pushed item not visible in queue");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

### sim/tb_top.sv
// Self-checking testbench for the multiscale tile maximum suppression block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POINT_W        = 2 * mtms_pkg::DIM_W + mtms_pkg::LEVEL_W +
                                    mtms_pkg::RADIUS_W;
    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 500;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 120;

    // Row sits in the lowest bits, as on m_tdata.
    typedef struct packed {
        logic [mtms_pkg::RADIUS_W-1:0] radius;
        logic [mtms_pkg::LEVEL_W-1:0]  level;
        logic [mtms_pkg::DIM_W-1:0]    col;
        logic [mtms_pkg::DIM_W-1:0]    row;
    } point_t;

    class tile_max_scoreboard;
        int unsigned tile_reg;
        int unsigned width_reg;
        int unsigned height_reg;
        int unsigned thr_reg;
        logic [mtms_pkg::RADIUS_W-1:0] radius_reg [mtms_pkg::LEVELS];

        int unsigned col_cnt;
        int unsigned row_cnt;
        int unsigned tile_off_col;
        int unsigned tile_off_row;
        int unsigned tile_col_idx;
        logic [mtms_pkg::RESP_W-1:0]  best_value [mtms_pkg::MAX_DIM];
        logic [mtms_pkg::DIM_W-1:0]   best_row   [mtms_pkg::MAX_DIM];
        logic [mtms_pkg::DIM_W-1:0]   best_col   [mtms_pkg::MAX_DIM];
        logic [mtms_pkg::LEVEL_W-1:0] best_level [mtms_pkg::MAX_DIM];

        point_t expected_points [$];
        int unsigned errors;
        int unsigned pixels;
        int unsigned points_predicted;
        int unsigned points_checked;

        function new();
            tile_reg   = 3;
            width_reg  = 512;
            height_reg = 512;
            thr_reg    = 0;
            for (int l = 0; l < mtms_pkg::LEVELS; l++) begin
                radius_reg[l] = '0;
            end
            restart_frame();
            errors = 0;
            pixels = 0;
            points_predicted = 0;
            points_checked = 0;
        endfunction

        function void restart_frame();
            col_cnt      = 0;
            row_cnt      = 0;
            tile_off_col = 0;
            tile_off_row = 0;
            tile_col_idx = 0;
        endfunction

        function int unsigned clamp_size(input int unsigned v);
            if (v == 0) begin
                return 1;
            end
            return (v > mtms_pkg::MAX_DIM) ? mtms_pkg::MAX_DIM : v;
        endfunction

        function void apply_register(input logic [2:0] idx,
                                     input logic [mtms_pkg::APB_DATA_W-1:0] value);
            case (idx)
                mtms_pkg::REG_TILE_SIZE: begin
                    tile_reg = 32'(value[mtms_pkg::TILE_W-1:0]);
                    restart_frame();
                end
                mtms_pkg::REG_WIDTH: begin
                    width_reg = 32'(value[mtms_pkg::SIZE_W-1:0]);
                    restart_frame();
                end
                mtms_pkg::REG_HEIGHT: begin
                    height_reg = 32'(value[mtms_pkg::SIZE_W-1:0]);
                    restart_frame();
                end
                mtms_pkg::REG_THRESHOLD: thr_reg = 32'(value[mtms_pkg::THR_W-1:0]);
                mtms_pkg::REG_RADIUS0: radius_reg[0] = value[mtms_pkg::RADIUS_W-1:0];
                mtms_pkg::REG_RADIUS1: radius_reg[1] = value[mtms_pkg::RADIUS_W-1:0];
                mtms_pkg::REG_RADIUS2: radius_reg[2] = value[mtms_pkg::RADIUS_W-1:0];
                mtms_pkg::REG_RADIUS3: radius_reg[3] = value[mtms_pkg::RADIUS_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(input logic [mtms_pkg::S_DATA_W-1:0] pix);
            int unsigned ts;
            int unsigned w;
            int unsigned h;
            int unsigned slot;
            bit in_frame;
            bit first;
            logic [mtms_pkg::RESP_W-1:0] v;
            point_t p;
            ts = (tile_reg == 0) ? 1 :
                 ((tile_reg > mtms_pkg::MAX_TILE) ? mtms_pkg::MAX_TILE : tile_reg);
            w = clamp_size(width_reg);
            h = clamp_size(height_reg);
            slot = tile_col_idx % mtms_pkg::MAX_DIM;
            in_frame = (tile_col_idx * ts + ts <= w) && (row_cnt - tile_off_row + ts <= h);
            pixels++;
            if (in_frame) begin
                first = (tile_off_col == 0) && (tile_off_row == 0);
                // Levels are scanned upward, so an equal value at a higher level takes over.
                for (int l = 0; l < mtms_pkg::LEVELS; l++) begin
                    v = pix[l*mtms_pkg::RESP_W +: mtms_pkg::RESP_W];
                    if ((first && l == 0) || v >= best_value[slot]) begin
                        best_value[slot] = v;
                        best_row[slot]   = row_cnt[mtms_pkg::DIM_W-1:0];
                        best_col[slot]   = col_cnt[mtms_pkg::DIM_W-1:0];
                        best_level[slot] = l[mtms_pkg::LEVEL_W-1:0];
                    end
                end
                if (tile_off_col == ts - 1 && tile_off_row == ts - 1 &&
                    32'(best_value[slot]) >= thr_reg) begin
                    p.row    = best_row[slot];
                    p.col    = best_col[slot];
                    p.level  = best_level[slot];
                    p.radius = radius_reg[best_level[slot]];
                    expected_points = {expected_points, p};
                    points_predicted++;
                end
            end
            col_cnt++;
            tile_off_col++;
            if (tile_off_col >= ts) begin
                tile_off_col = 0;
                tile_col_idx++;
            end
            if (col_cnt >= w) begin
                col_cnt = 0;
                tile_off_col = 0;
                tile_col_idx = 0;
                row_cnt++;
                tile_off_row++;
                if (tile_off_row >= ts) begin
                    tile_off_row = 0;
                end
                if (row_cnt >= h) begin
                    row_cnt = 0;
                    tile_off_row = 0;
                end
            end
        endfunction

        function void check_point(input logic [mtms_pkg::M_DATA_W-1:0] data);
            point_t want;
            point_t got;
            logic [mtms_pkg::M_DATA_W-POINT_W-1:0] pad;
            got = data[POINT_W-1:0];
            pad = data[mtms_pkg::M_DATA_W-1:POINT_W];
            if (expected_points.size() == 0) begin
                $error("unexpected detection item: m_tdata 0x%h", data);
                errors++;
                return;
            end
            want = expected_points.pop_front();
            points_checked++;
            if (got.row !== want.row) begin
                $error("point_row: expected %0d, actual %0d", want.row, got.row);
                errors++;
            end
            if (got.col !== want.col) begin
                $error("point_col: expected %0d, actual %0d", want.col, got.col);
                errors++;
            end
            if (got.level !== want.level) begin
                $error("point_level: expected %0d, actual %0d", want.level, got.level);
                errors++;
            end
            if (got.radius !== want.radius) begin
                $error("point_radius: expected 0x%h, actual 0x%h", want.radius, got.radius);
                errors++;
            end
            if (pad !== '0) begin
                $error("padding: expected 0, actual 0x%h", pad);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_points.size();
        endfunction
    endclass

    logic                              aclk     = 1'b0;
    logic                              aresetn  = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // response_level0 [7:0], response_level1 [15:8], response_level2 [23:16],
    // response_level3 [31:24]
    logic [mtms_pkg::S_DATA_W-1:0]     s_tdata  = '0;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // point_row [9:0], point_col [19:10], point_level [21:20], point_radius [37:22],
    // zero [39:38]
    logic [mtms_pkg::M_DATA_W-1:0]     m_tdata;
    logic                              psel     = 1'b0;
    logic                              penable  = 1'b0;
    logic                              pwrite   = 1'b0;
    logic [mtms_pkg::APB_ADDR_W-1:0]   paddr    = '0;
    logic [mtms_pkg::APB_DATA_W-1:0]   pwdata   = '0;
    logic [mtms_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;

    tile_max_scoreboard board = new();
    bit gaps_on      = 1'b1;
    bit hold_request = 1'b0;

    multiscale_tile_max_suppression i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #6 aclk = ~aclk;

    task automatic write_reg(input logic [2:0] idx,
                             input logic [mtms_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.apply_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_geometry(input int unsigned ts, input int unsigned w,
                                input int unsigned h);
        write_reg(mtms_pkg::REG_TILE_SIZE, ts);
        write_reg(mtms_pkg::REG_WIDTH, w);
        write_reg(mtms_pkg::REG_HEIGHT, h);
    endtask

    task automatic set_levels(input int unsigned thr, input int unsigned r0,
                              input int unsigned r1, input int unsigned r2,
                              input int unsigned r3);
        write_reg(mtms_pkg::REG_THRESHOLD, thr);
        write_reg(mtms_pkg::REG_RADIUS0, r0);
        write_reg(mtms_pkg::REG_RADIUS1, r1);
        write_reg(mtms_pkg::REG_RADIUS2, r2);
        write_reg(mtms_pkg::REG_RADIUS3, r3);
    endtask

    task automatic send_pixel(input logic [mtms_pkg::S_DATA_W-1:0] pix);
        while (gaps_on && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        board.note_pixel(pix);
    endtask

    // A pixel that ends no tile leaves no trace, so the drain waits on after the last expected detection.
    task automatic drain_detections();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int unsigned pick_threshold();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20) begin
            return 0;
        end else if (roll < 30) begin
            return 256;
        end else if (roll < 40) begin
            return $urandom_range(511, 257);
        end else if (roll < 70) begin
            return $urandom_range(64, 0);
        end
        return $urandom_range(255, 0);
    endfunction

    function automatic int unsigned pick_radius();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return 0;
        end else if (roll < 20) begin
            return 'hFFFF;
        end
        return $urandom_range('hFFFF, 0);
    endfunction

    // Style 0 is uniform, style 1 keeps values tiny so ties are common, style 2 favors extremes.
    function automatic logic [mtms_pkg::S_DATA_W-1:0] random_pixel(input int unsigned style);
        logic [mtms_pkg::S_DATA_W-1:0] pix;
        logic [mtms_pkg::RESP_W-1:0] v;
        for (int l = 0; l < mtms_pkg::LEVELS; l++) begin
            case (style)
                0: v = mtms_pkg::RESP_W'($urandom_range(255, 0));
                1: v = mtms_pkg::RESP_W'($urandom_range(2, 0));
                default: begin
                    case ($urandom_range(2, 0))
                        0: v = 8'h00;
                        1: v = 8'hFF;
                        default: v = mtms_pkg::RESP_W'($urandom_range(255, 0));
                    endcase
                end
            endcase
            pix[l*mtms_pkg::RESP_W +: mtms_pkg::RESP_W] = v;
        end
        return pix;
    endfunction

    initial begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) begin
                board.check_point(m_tdata);
            end
            if (hold_request) begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(gaps_on && $urandom_range(99) < 27);
            end
        end
    end

    initial begin : watchdog
        #3ms;
        $display("multiscale_tile_max_suppression regression: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned style;
        int unsigned roll;
        int unsigned ts;
        logic [mtms_pkg::RESP_W-1:0] v;
        logic [mtms_pkg::S_DATA_W-1:0] pix;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset defaults: tile 3 on a 512 by 512 frame, nothing completes yet.
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        drain_detections();

        // Zero tile size acts as one, so every pixel is a tile; the frame wraps after six.
        set_geometry(0, 3, 2);
        set_levels(0, 'h0000, 'hFFFF, 'h1234, 'h8001);
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_00FF);
        send_pixel(32'h01FF_0203);
        send_pixel(32'h00FF_00FF);
        send_pixel(32'h8080_8080);
        send_pixel(32'h7F00_FF00);
        send_pixel(32'hFF00_0000);
        drain_detections();

        // Partial tiles on the right and bottom carry 255 and must stay silent; the first
        // tile only just meets the threshold and the second falls one short.
        set_geometry(2, 5, 3);
        set_levels(200, 'h0100, 'h0200, 'h0300, 'h0400);
        for (int p = 0; p < 15; p++) begin
            for (int l = 0; l < mtms_pkg::LEVELS; l++) begin
                if (p == 6 && (l == 0 || l == 3)) begin
                    v = 8'd200;
                end else if (p % 5 == 4 || p >= 10) begin
                    v = 8'd255;
                end else begin
                    v = 8'd199;
                end
                pix[l*mtms_pkg::RESP_W +: mtms_pkg::RESP_W] = v;
            end
            send_pixel(pix);
        end
        drain_detections();

        phase = 0;
        while (board.pixels < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            phase++;
            gaps_on = (phase > 3);
            n = $urandom_range(60, 4);
            style = $urandom_range(2, 0);
            if (phase == 1) begin
                // Every pixel is a detection while the sink holds off, so the input backs up.
                set_geometry(1, 8, 8);
                set_levels(0, pick_radius(), pick_radius(), pick_radius(), pick_radius());
                hold_request = 1'b1;
                n = 64;
                style = 0;
            end else if (phase == 6) begin
                set_geometry(15, 16, 15);
                set_levels($urandom_range(128, 0), pick_radius(), pick_radius(),
                           pick_radius(), pick_radius());
                n = 240;
            end else begin
                roll = $urandom_range(99);
                if (roll < 10) begin
                    case ($urandom_range(2, 0))
                        0: set_geometry(0, 2047, 2047);
                        1: set_geometry(15, 1024, 1024);
                        default: set_geometry(3, 0, 0);
                    endcase
                    n = 30;
                end else if (roll < 25) begin
                    ts = $urandom_range(7, 5);
                    set_geometry(ts, $urandom_range(2 * ts + 1, ts),
                                 $urandom_range(2 * ts + 1, ts));
                end else if (roll < 75) begin
                    set_geometry($urandom_range(4, 0), $urandom_range(12, 0),
                                 $urandom_range(12, 0));
                end
                // Otherwise the frame carries on and only threshold and radii change.
                set_levels(pick_threshold(), pick_radius(), pick_radius(),
                           pick_radius(), pick_radius());
            end
            repeat (n) send_pixel(random_pixel(style));
            drain_detections();
        end

        repeat (4 * SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d pixels over %0d random phases plus directed edge cases;",
                 board.pixels, phase);
        $display("%0d tile detections were predicted and %0d compared.",
                 board.points_predicted, board.points_checked);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("multiscale_tile_max_suppression regression: pass");
        end else begin
            $display("multiscale_tile_max_suppression regression: fail");
        end
        $finish;
    end

endmodule

### sim.f
hdl/mtms_pkg.sv
hdl/mtms_ram.sv
hdl/mtms_front.sv
hdl/mtms_queue.sv
hdl/mtms_back.sv
hdl/multiscale_tile_max_suppression.sv
sim/tb_top.sv
